@@ rtl/ott_pkg.sv @@
// Package for the outstanding transfer tracker: field widths, command and
// status codes, the result record and the slot evaluation response.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ott_pkg;

    localparam int CMD_W       = 2;
    localparam int ID_W        = 32;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 3;
    localparam int TIME_W      = 32;
    localparam int TMO_W       = 16;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd1000;

    typedef enum logic [CMD_W-1:0] {
        CMD_START    = 2'd0,
        CMD_COMPLETE = 2'd1,
        CMD_ERROR    = 2'd2,
        CMD_TICK     = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED    = 3'd0,
        ST_FULL      = 3'd1,
        ST_COMPLETED = 3'd2,
        ST_ERRORED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_TIMED_OUT = 3'd5
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] age;
        logic              last;
    } t_result;

    typedef struct packed {
        logic              hit;
        logic [TIME_W-1:0] age;
    } t_eval_rsp;

endpackage
`default_nettype wire

@@ rtl/ott_slot_eval.sv @@
// Shared slot evaluation unit: one table entry against the current command.
// Free test for start, id match for complete/error, age compare for tick.
// Depends on ott_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ott_slot_eval (
    input  var ott_pkg::t_cmd            i_cmd,
    input  wire                          i_valid,
    input  wire  [ott_pkg::ID_W-1:0]     i_req_id,
    input  wire  [ott_pkg::ID_W-1:0]     i_entry_id,
    input  wire  [ott_pkg::TIME_W-1:0]   i_entry_start,
    input  wire  [ott_pkg::TIME_W-1:0]   i_now,
    input  wire  [ott_pkg::TMO_W-1:0]    i_timeout,
    output ott_pkg::t_eval_rsp           o_rsp
);
    import ott_pkg::*;

    logic [TIME_W-1:0] w_age;

    assign w_age = i_now - i_entry_start;

    always_comb begin
        o_rsp.age = w_age;
        case (i_cmd)
            CMD_START: begin
                o_rsp.hit = !i_valid;
            end
            CMD_COMPLETE, CMD_ERROR: begin
                o_rsp.hit = i_valid && (i_entry_id == i_req_id);
            end
            default: begin
                o_rsp.hit = i_valid && (w_age > TIME_W'(i_timeout));
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/outstanding_transfer_tracker_top.sv @@
// Outstanding transfer tracker: table of in-flight transfers with timeout.
// The slot scan reads one table entry per cycle through one shared evaluator.
// Throughput: one command per scan; busy stays high until the last result.
// Tick results stream out as expired slots are found, at most one per cycle (max 8 per tick).
// Reset (sync, active low): all slots free, counter zero, timeout 1000.
`timescale 1ns / 1ps
`default_nettype none
module outstanding_transfer_tracker_top #(
    parameter int SLOTS = 8
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [ott_pkg::TMO_W-1:0]       i_cfg_wdata,
    input  wire                             i_start,
    output logic                            o_busy,
    input  wire  [ott_pkg::CMD_W-1:0]       i_cmd,
    input  wire  [ott_pkg::ID_W-1:0]        i_transfer_id,
    output logic                            o_strobe,
    output logic [ott_pkg::STATUS_W-1:0]    o_status,
    output logic [ott_pkg::ID_W-1:0]        o_result_id,
    output logic [ott_pkg::SLOT_W-1:0]      o_slot,
    output logic [ott_pkg::TIME_W-1:0]      o_age_ms,
    output logic                            o_last
);
    import ott_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    logic [ID_W-1:0]   r_req_id;
    logic [TIME_W-1:0] r_now;
    logic [TMO_W-1:0]  r_timeout;
    logic [SLOTS-1:0]  r_valid;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [IDX_W-1:0]  r_ev_idx;
    logic              r_ev_vld;
    logic [ID_W-1:0]   r_rd_id;
    logic [TIME_W-1:0] r_rd_start;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_pend_vld;
    t_result           r_pend;
    logic              r_strobe;
    t_result           r_res;

    logic [ID_W-1:0]   mem_id    [SLOTS];
    logic [TIME_W-1:0] mem_start [SLOTS];

    t_eval_rsp         w_eval;
    logic              w_wr_en;
    logic [SLOT_W-1:0] w_slot;

    ott_slot_eval u_eval (
        .i_cmd         (r_cmd),
        .i_valid       (r_valid[r_ev_idx]),
        .i_req_id      (r_req_id),
        .i_entry_id    (r_rd_id),
        .i_entry_start (r_rd_start),
        .i_now         (r_now),
        .i_timeout     (r_timeout),
        .o_rsp         (w_eval)
    );

    assign w_slot  = SLOT_W'(r_ev_idx);
    assign w_wr_en = (r_state == S_SCAN) && r_ev_vld && w_eval.hit && (r_cmd == CMD_START);

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_id[r_ev_idx]    <= r_req_id;
            mem_start[r_ev_idx] <= r_now;
        end
        r_rd_id    <= mem_id[r_rd_idx];
        r_rd_start <= mem_start[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_now      <= '0;
            r_timeout  <= TIMEOUT_RST;
            r_valid    <= '0;
            r_ev_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_cnt      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd      <= t_cmd'(i_cmd);
                        r_req_id   <= i_transfer_id;
                        r_rd_idx   <= '0;
                        r_ev_vld   <= 1'b0;
                        r_pend_vld <= 1'b0;
                        r_cnt      <= '0;
                        r_state    <= S_SCAN;
                        if (t_cmd'(i_cmd) == CMD_TICK) begin
                            r_now <= r_now + 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    r_ev_idx <= r_rd_idx;
                    r_ev_vld <= 1'b1;
                    if (r_rd_idx != LAST_IDX) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    if (r_ev_vld) begin
                        if (w_eval.hit) begin
                            case (r_cmd)
                                CMD_START: begin
                                    r_valid[r_ev_idx] <= 1'b1;
                                    r_strobe <= 1'b1;
                                    r_res    <= '{ST_STORED, r_req_id, w_slot, '0, 1'b1};
                                    r_state  <= S_IDLE;
                                end
                                CMD_COMPLETE: begin
                                    r_valid[r_ev_idx] <= 1'b0;
                                    r_strobe <= 1'b1;
                                    r_res    <= '{ST_COMPLETED, r_req_id, w_slot, '0, 1'b1};
                                    r_state  <= S_IDLE;
                                end
                                CMD_ERROR: begin
                                    r_valid[r_ev_idx] <= 1'b0;
                                    r_strobe <= 1'b1;
                                    r_res    <= '{ST_ERRORED, r_req_id, w_slot, '0, 1'b1};
                                    r_state  <= S_IDLE;
                                end
                                default: begin
                                    // tick: hold each expiry until the next one shows or the scan ends
                                    r_valid[r_ev_idx] <= 1'b0;
                                    if (r_pend_vld) begin
                                        r_strobe <= 1'b1;
                                        r_res    <= r_pend;
                                    end
                                    r_pend     <= '{ST_TIMED_OUT, r_rd_id, w_slot,
                                                    w_eval.age, 1'b0};
                                    r_pend_vld <= 1'b1;
                                    r_cnt      <= r_cnt + 1'b1;
                                    if (r_cnt == CNT_W'(MAX_RESULTS - 1) ||
                                        r_ev_idx == LAST_IDX) begin
                                        r_state <= S_FLUSH;
                                    end
                                end
                            endcase
                        end else if (r_ev_idx == LAST_IDX) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    r_state <= S_IDLE;
                    case (r_cmd)
                        CMD_START: begin
                            r_strobe <= 1'b1;
                            r_res    <= '{ST_FULL, r_req_id, '0, '0, 1'b1};
                        end
                        CMD_COMPLETE, CMD_ERROR: begin
                            r_strobe <= 1'b1;
                            r_res    <= '{ST_NOT_FOUND, r_req_id, '0, '0, 1'b1};
                        end
                        default: begin
                            if (r_pend_vld) begin
                                r_strobe <= 1'b1;
                                r_res    <= '{r_pend.status, r_pend.id, r_pend.slot,
                                              r_pend.age, 1'b1};
                            end
                            r_pend_vld <= 1'b0;
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_status    = r_res.status;
    assign o_result_id = r_res.id;
    assign o_slot      = r_res.slot;
    assign o_age_ms    = r_res.age;
    assign o_last      = r_res.last;

endmodule
`default_nettype wire

@@ rtl/ott_checker.sv @@
// Port-level checker for the outstanding transfer tracker, bound to the top.
// Depends on ott_pkg and outstanding_transfer_tracker_top.
`timescale 1ns / 1ps
`default_nettype none
module ott_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_start,
    input wire                           o_busy,
    input wire                           o_strobe,
    input wire [ott_pkg::STATUS_W-1:0]   o_status,
    input wire [ott_pkg::TIME_W-1:0]     o_age_ms,
    input wire                           o_last
);
    import ott_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("busy not raised after accepted transfer");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !o_busy)
        else $error("still busy on final result");

    a_mid_is_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> o_busy && (o_status == ST_TIMED_OUT))
        else $error("non-final result that is not a timeout");

    a_age_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_TIMED_OUT) |-> (o_age_ms == '0) && o_last)
        else $error("age or last wrong on single result");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status <= ST_TIMED_OUT))
        else $error("status code out of range");

endmodule

bind outstanding_transfer_tracker_top ott_checker u_ott_checker (.*);
`default_nettype wire
